// File: design/tea_block_cipher_macros.svh
// Assertion macros for the TEA block cipher.
// Used by any design file that asserts; expects clk and rst_n in scope.
`ifndef TEA_BLOCK_CIPHER_MACROS_SVH
`define TEA_BLOCK_CIPHER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define TEA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tea assertion failed");

// Next-cycle implication, disabled in reset.
`define TEA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tea assertion failed");

`endif

// File: design/tea_pkg.sv
// Shared types and constants for the TEA block cipher.
// No dependencies; imported by every other design file but the macros header.
`timescale 1ns / 1ps

package tea_pkg;

    localparam int WORD_W  = 32;
    localparam int CYC_W   = 8;
    localparam int INDEX_W = 3;

    localparam logic [WORD_W-1:0] DELTA_RESET  = 32'h9E37_79B9;
    localparam logic [CYC_W-1:0]  CYCLES_RESET = 8'd32;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [INDEX_W-1:0] {
        CFG_KEY0    = 3'd0,
        CFG_KEY1    = 3'd1,
        CFG_KEY2    = 3'd2,
        CFG_KEY3    = 3'd3,
        CFG_DELTA   = 3'd4,
        CFG_CYCLES  = 3'd5,
        CFG_DECRYPT = 3'd6
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    typedef struct packed {
        logic load;
        logic step_a;
        logic step_b;
        logic adv_sum;
        logic finish;
    } ctl_t;

endpackage

// File: design/tea_in_if.sv
// Request channel carrying one 64-bit block as two 32-bit halves.
// Depends on tea_pkg.
`timescale 1ns / 1ps

interface tea_in_if
    import tea_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t word_high;
    word_t word_low;

    modport source (output valid, output word_high, output word_low, input ready);
    modport sink   (input valid, input word_high, input word_low, output ready);
endinterface

// File: design/tea_out_if.sv
// Result channel carrying one 64-bit block as two 32-bit halves.
// Depends on tea_pkg.
`timescale 1ns / 1ps

interface tea_out_if
    import tea_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t out_high;
    word_t out_low;

    modport source (output valid, output out_high, output out_low, input ready);
    modport sink   (input valid, input out_high, input out_low, output ready);
endinterface

// File: design/tea_cell.sv
// Round cell: holds one half of the block and applies one Feistel round to it
// from the neighbor's half. Depends on tea_pkg.
`timescale 1ns / 1ps

module tea_cell
    import tea_pkg::*;
(
    input  logic  clk,
    input  logic  load,
    input  logic  step,
    input  logic  decrypt,
    input  word_t load_val,
    input  word_t other,
    input  word_t sum,
    input  word_t ka,
    input  word_t kb,
    output word_t half
);

    word_t half_reg;
    word_t half_next;
    word_t mix;

    assign mix = (other + sum) ^ ((other << 4) + ka) ^ ((other >> 5) + kb);

    always_comb
    begin
        if (load)
        begin
            half_next = load_val;
        end
        else if (step)
        begin
            half_next = decrypt ? (half_reg - mix) : (half_reg + mix);
        end
        else
        begin
            half_next = half_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        half_reg <= half_next;
    end

    assign half = half_reg;

endmodule

// File: design/tea_seq.sv
// Sequencer: steps the two round cells in turn and manages the result slot.
// Depends on tea_pkg and tea_block_cipher_macros.svh.
`timescale 1ns / 1ps
`include "tea_block_cipher_macros.svh"

module tea_seq
    import tea_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             rsp_ready,
    input  logic [CYC_W-1:0] cycle_count,
    input  logic             decrypt,
    output ctl_t             ctl,
    output logic             req_ready,
    output logic             rsp_valid
);

    state_t           state_reg, state_next;
    logic [CYC_W-1:0] count_reg, count_next;
    logic             first_reg, first_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic             run;

    assign run       = (state_reg == ST_RUN);
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        first_next     = first_reg;
        rsp_valid_next = rsp_valid_reg & ~rsp_ready;
        ctl            = '0;
        ctl.step_a     = run & (first_reg ^ decrypt);
        ctl.step_b     = run & ~(first_reg ^ decrypt);
        ctl.adv_sum    = run & ~first_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.load   = 1'b1;
                    count_next = cycle_count;
                    first_next = 1'b1;
                    state_next = (cycle_count == '0) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN:
            begin
                first_next = ~first_reg;
                if (!first_reg)
                begin
                    count_next = count_reg - 1'b1;
                    if (count_reg == 8'd1)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    ctl.finish     = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            first_reg     <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            first_reg     <= first_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    `TEA_ASSERT_IMP(a_run_count, state_reg == ST_RUN, count_reg != 8'd0)
    `TEA_ASSERT_NXT(a_load_busy, ctl.load, state_reg != ST_IDLE)
    `TEA_ASSERT_NXT(a_count_dec, (state_reg == ST_RUN) && !first_reg, (count_reg == ($past(count_reg) - 8'd1)) && first_reg)
    `TEA_ASSERT_NXT(a_finish_out, ctl.finish, rsp_valid_reg && (state_reg == ST_IDLE))

endmodule

// File: design/tea_block_cipher.sv
// Top level of the TEA block cipher: configuration registers, running sum,
// two round cells and the result register. Depends on tea_pkg, the channel
// interfaces, tea_cell and tea_seq.
//
//  channel  dir   payload                  handshake
//  req      in    word_high, word_low      req.valid / req.ready
//  rsp      out   out_high, out_low        rsp.valid / rsp.ready
//  cfg      in    cfg_index, cfg_wdata     cfg_we (no wait)
//
// From acceptance to result valid the two round cells alternate, one round a
// clock, and then, once the result register is free, the block moves into it.
// A new block is accepted once the cells are free, even while the last result
// still waits in the result register; a stalled result holds the cells.
// Reset clears control state and restores the configuration reset values.
`timescale 1ns / 1ps

module tea_block_cipher
    import tea_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    tea_in_if.sink             req,
    tea_out_if.source          rsp,
    input  logic               cfg_we,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]  cfg_wdata
);

    word_t            key0_reg, key1_reg, key2_reg, key3_reg, delta_reg;
    logic [CYC_W-1:0] cycles_reg;
    logic             decrypt_reg;
    word_t            sum_reg, sum_next;
    word_t            out_high_reg, out_low_reg;
    word_t            half_a, half_b;
    word_t            sum_start;
    ctl_t             ctl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg    <= '0;
            key1_reg    <= '0;
            key2_reg    <= '0;
            key3_reg    <= '0;
            delta_reg   <= DELTA_RESET;
            cycles_reg  <= CYCLES_RESET;
            decrypt_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY0:    key0_reg    <= cfg_wdata;
                CFG_KEY1:    key1_reg    <= cfg_wdata;
                CFG_KEY2:    key2_reg    <= cfg_wdata;
                CFG_KEY3:    key3_reg    <= cfg_wdata;
                CFG_DELTA:   delta_reg   <= cfg_wdata;
                CFG_CYCLES:  cycles_reg  <= cfg_wdata[CYC_W-1:0];
                CFG_DECRYPT: decrypt_reg <= cfg_wdata[0];
                default:     ;
            endcase
        end
    end

    assign sum_start = decrypt_reg ? (delta_reg * {{(WORD_W-CYC_W){1'b0}}, cycles_reg})
                                   : delta_reg;

    always_comb
    begin
        if (ctl.load)
        begin
            sum_next = sum_start;
        end
        else if (ctl.adv_sum)
        begin
            sum_next = decrypt_reg ? (sum_reg - delta_reg) : (sum_reg + delta_reg);
        end
        else
        begin
            sum_next = sum_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (ctl.finish)
        begin
            out_high_reg <= half_a;
            out_low_reg  <= half_b;
        end
    end

    tea_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .rsp_ready   (rsp.ready),
        .cycle_count (cycles_reg),
        .decrypt     (decrypt_reg),
        .ctl         (ctl),
        .req_ready   (req.ready),
        .rsp_valid   (rsp.valid)
    );

    tea_cell u_cell_a (
        .clk      (clk),
        .load     (ctl.load),
        .step     (ctl.step_a),
        .decrypt  (decrypt_reg),
        .load_val (req.word_high),
        .other    (half_b),
        .sum      (sum_reg),
        .ka       (key0_reg),
        .kb       (key1_reg),
        .half     (half_a)
    );

    tea_cell u_cell_b (
        .clk      (clk),
        .load     (ctl.load),
        .step     (ctl.step_b),
        .decrypt  (decrypt_reg),
        .load_val (req.word_low),
        .other    (half_a),
        .sum      (sum_reg),
        .ka       (key2_reg),
        .kb       (key3_reg),
        .half     (half_b)
    );

    assign rsp.out_high = out_high_reg;
    assign rsp.out_low  = out_low_reg;

endmodule

// File: tb/tea_block_cipher_tb.sv
// Self-checking testbench for tea_block_cipher: directed table, then random configurations.
// Checks each result block against an in-bench TEA predictor kept in step with the register writes, or a literal row.
// Depends on tea_pkg, tea_in_if, tea_out_if and the tea_block_cipher RTL.
`timescale 1ns / 1ps

module tea_block_cipher_tb;
    import tea_pkg::*;

    localparam int          HALF_PERIOD    = 10;
    localparam int          RESET_CYCLES   = 11;
    localparam int          HOLD_CYCLES    = 600;
    localparam int          HOLD_AFTER     = 40;
    localparam int          TAIL_CYCLES    = 600;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int          DIRECTED_ROWS  = 16;

    localparam logic              MODE_ENCRYPT  = 1'b0;
    localparam logic              MODE_DECRYPT  = 1'b1;
    localparam logic              CHECK_MODEL   = 1'b0;
    localparam logic              CHECK_LITERAL = 1'b1;
    localparam logic [INDEX_W-1:0] CFG_UNMAPPED = 3'd7;
    localparam word_t             ALL_ONES      = 32'hFFFF_FFFF;

    typedef struct packed {
        word_t high;
        word_t low;
    } block_t;

    typedef struct packed {
        logic [CYC_W-1:0] cycles;
        logic             decrypt;
        logic             check;
        word_t            high;
        word_t            low;
        word_t            exp_high;
        word_t            exp_low;
    } vector_t;

    localparam vector_t DIRECTED [DIRECTED_ROWS] = '{
        '{8'd32,  MODE_ENCRYPT, CHECK_MODEL,   32'h0000_0000, 32'h0000_0000, 32'h0, 32'h0},
        '{8'd32,  MODE_ENCRYPT, CHECK_MODEL,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0},
        '{8'd32,  MODE_ENCRYPT, CHECK_MODEL,   32'hFFFF_FFFF, 32'h0000_0000, 32'h0, 32'h0},
        '{8'd32,  MODE_ENCRYPT, CHECK_MODEL,   32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0},
        '{8'd32,  MODE_ENCRYPT, CHECK_MODEL,   32'h8000_0000, 32'h0000_0001, 32'h0, 32'h0},
        '{8'd32,  MODE_DECRYPT, CHECK_MODEL,   32'h0000_0000, 32'h0000_0000, 32'h0, 32'h0},
        '{8'd32,  MODE_DECRYPT, CHECK_MODEL,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0},
        '{8'd32,  MODE_DECRYPT, CHECK_MODEL,   32'h1234_5678, 32'h9ABC_DEF0, 32'h0, 32'h0},
        '{8'd0,   MODE_ENCRYPT, CHECK_LITERAL, 32'h0123_4567, 32'h89AB_CDEF,
                                               32'h0123_4567, 32'h89AB_CDEF},
        '{8'd0,   MODE_ENCRYPT, CHECK_LITERAL, 32'hFFFF_FFFF, 32'h0000_0000,
                                               32'hFFFF_FFFF, 32'h0000_0000},
        '{8'd0,   MODE_DECRYPT, CHECK_LITERAL, 32'hFEDC_BA98, 32'h7654_3210,
                                               32'hFEDC_BA98, 32'h7654_3210},
        '{8'd1,   MODE_DECRYPT, CHECK_MODEL,   32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h0, 32'h0},
        '{8'd1,   MODE_ENCRYPT, CHECK_MODEL,   32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0, 32'h0},
        '{8'd2,   MODE_ENCRYPT, CHECK_MODEL,   32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h0, 32'h0},
        '{8'd255, MODE_ENCRYPT, CHECK_MODEL,   32'h0000_0000, 32'h0000_0000, 32'h0, 32'h0},
        '{8'd255, MODE_DECRYPT, CHECK_MODEL,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0}
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [INDEX_W-1:0] cfg_index;
    word_t              cfg_wdata;

    tea_in_if  req_if ();
    tea_out_if rsp_if ();

    tea_block_cipher uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predictor copy of the configuration
    word_t            cur_key [4];
    word_t            cur_delta;
    logic [CYC_W-1:0] cur_cycles;
    logic             cur_decrypt;

    block_t expected_blocks [$];
    int     errors         = 0;
    int     blocks_checked = 0;
    logic   hold_off;

    always #HALF_PERIOD clk = ~clk;

    function automatic word_t round_mix(word_t v, word_t sum, word_t ka, word_t kb);
        return (v + sum) ^ ((v << 4) + ka) ^ ((v >> 5) + kb);
    endfunction

    function automatic block_t tea_predict(word_t high, word_t low);
        word_t a;
        word_t b;
        word_t sum;
        a = high;
        b = low;
        if (cur_decrypt == MODE_ENCRYPT)
        begin
            sum = '0;
            for (int i = 0; i < cur_cycles; i++)
            begin
                sum = sum + cur_delta;
                a   = a + round_mix(b, sum, cur_key[0], cur_key[1]);
                b   = b + round_mix(a, sum, cur_key[2], cur_key[3]);
            end
        end
        else
        begin
            sum = cur_delta * cur_cycles;
            for (int i = 0; i < cur_cycles; i++)
            begin
                b   = b - round_mix(a, sum, cur_key[2], cur_key[3]);
                a   = a - round_mix(b, sum, cur_key[0], cur_key[1]);
                sum = sum - cur_delta;
            end
        end
        return '{high: a, low: b};
    endfunction

    // fill the bits above the register width with noise
    function automatic word_t with_junk(word_t value, word_t keep);
        return ($urandom() & ~keep) | (value & keep);
    endfunction

    function automatic word_t pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return ALL_ONES;
            2: return word_t'(1) << $urandom_range(0, WORD_W - 1);
            3: return ~(word_t'(1) << $urandom_range(0, WORD_W - 1));
            default: return $urandom();
        endcase
    endfunction

    task automatic write_reg(logic [INDEX_W-1:0] idx, word_t value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_KEY0:    cur_key[0]  = value;
            CFG_KEY1:    cur_key[1]  = value;
            CFG_KEY2:    cur_key[2]  = value;
            CFG_KEY3:    cur_key[3]  = value;
            CFG_DELTA:   cur_delta   = value;
            CFG_CYCLES:  cur_cycles  = value[CYC_W-1:0];
            CFG_DECRYPT: cur_decrypt = value[0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (expected_blocks.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic send_block(word_t high, word_t low, block_t want);
        req_if.valid     <= 1'b1;
        req_if.word_high <= high;
        req_if.word_low  <= low;
        do
        begin
            @(posedge clk);
        end
        while (!req_if.ready);
        expected_blocks.push_back(want);
    endtask

    task automatic load_config(word_t k0, word_t k1, word_t k2, word_t k3, word_t dlt,
                               logic [CYC_W-1:0] cycles, logic decrypt);
        wait_idle();
        write_reg(CFG_KEY0, k0);
        write_reg(CFG_KEY1, k1);
        write_reg(CFG_KEY2, k2);
        write_reg(CFG_KEY3, k3);
        write_reg(CFG_DELTA, dlt);
        write_reg(CFG_CYCLES, with_junk(word_t'(cycles), 32'h0000_00FF));
        write_reg(CFG_DECRYPT, with_junk(word_t'(decrypt), 32'h0000_0001));
        if ($urandom_range(0, 1) == 0)
            write_reg(CFG_UNMAPPED, $urandom());
    endtask

    task automatic run_random(int unsigned count);
        int unsigned left;
        int unsigned burst;
        word_t       high;
        word_t       low;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            if (burst > left)
                burst = left;
            repeat (burst)
            begin
                high = pick_word();
                low  = pick_word();
                send_block(high, low, tea_predict(high, low));
            end
            left = left - burst;
            if ($urandom_range(0, 3) != 0)
            begin
                req_if.valid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    endtask

    // receiver: stall pattern steps through four modes, chosen by rx_tick[9:8]
    initial
    begin
        logic [15:0] rx_tick;
        rx_tick       = '0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rx_tick = rx_tick + 1'b1;
            if (hold_off)
                rsp_if.ready <= 1'b0;
            else
                case (rx_tick[9:8])
                    2'd0: rsp_if.ready <= 1'b1;
                    2'd1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
                    2'd2: rsp_if.ready <= ($urandom_range(0, 1) != 0);
                    default: rsp_if.ready <= (rx_tick[2:0] != 3'd0);
                endcase
        end
    end

    // hold off the receiver long enough to back up the input
    initial
    begin
        hold_off = 1'b0;
        wait (blocks_checked >= HOLD_AFTER);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin : check_results
        block_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_blocks.size() == 0)
            begin
                $display("%0t MISMATCH unexpected result: expected none actual %h %h",
                         $time, rsp_if.out_high, rsp_if.out_low);
                errors++;
            end
            else
            begin
                want = expected_blocks.pop_front();
                if (rsp_if.out_high !== want.high)
                begin
                    $display("%0t MISMATCH out_high: expected %h actual %h",
                             $time, want.high, rsp_if.out_high);
                    errors++;
                end
                if (rsp_if.out_low !== want.low)
                begin
                    $display("%0t MISMATCH out_low: expected %h actual %h",
                             $time, want.low, rsp_if.out_low);
                    errors++;
                end
                blocks_checked++;
            end
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_we || (req_if.valid && req_if.ready)
                || (rsp_if.valid && rsp_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t watchdog: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        block_t want;
        word_t  rk [4];
        rst_n            <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.word_high <= '0;
        req_if.word_low  <= '0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_wdata        <= '0;
        for (int i = 0; i < 4; i++)
            cur_key[i] = '0;
        cur_delta   = DELTA_RESET;
        cur_cycles  = CYCLES_RESET;
        cur_decrypt = MODE_ENCRYPT;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // must leave the reset configuration alone
        write_reg(CFG_UNMAPPED, ALL_ONES);

        foreach (DIRECTED[r])
        begin
            if (DIRECTED[r].cycles != cur_cycles || DIRECTED[r].decrypt != cur_decrypt)
            begin
                wait_idle();
                write_reg(CFG_CYCLES, with_junk(word_t'(DIRECTED[r].cycles), 32'h0000_00FF));
                write_reg(CFG_DECRYPT, with_junk(word_t'(DIRECTED[r].decrypt), 32'h0000_0001));
            end
            if (DIRECTED[r].check == CHECK_LITERAL)
                want = '{high: DIRECTED[r].exp_high, low: DIRECTED[r].exp_low};
            else
                want = tea_predict(DIRECTED[r].high, DIRECTED[r].low);
            send_block(DIRECTED[r].high, DIRECTED[r].low, want);
        end

        for (int i = 0; i < 4; i++)
            rk[i] = $urandom();
        load_config(rk[0], rk[1], rk[2], rk[3], DELTA_RESET, CYCLES_RESET, MODE_ENCRYPT);
        run_random(250);
        load_config(rk[0], rk[1], rk[2], rk[3], DELTA_RESET, CYCLES_RESET, MODE_DECRYPT);
        run_random(250);
        load_config(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 8'd5, MODE_ENCRYPT);
        run_random(120);
        load_config('0, '0, '0, '0, '0, 8'd3, MODE_DECRYPT);
        run_random(80);
        repeat (6)
        begin
            load_config($urandom(), $urandom(), $urandom(), $urandom(), pick_word(),
                        CYC_W'($urandom_range(0, 12)), logic'($urandom_range(0, 1)));
            run_random(80);
        end
        load_config($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                    8'd255, MODE_ENCRYPT);
        run_random(6);
        load_config($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                    8'd255, MODE_DECRYPT);
        run_random(6);
        load_config($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                    8'd0, logic'($urandom_range(0, 1)));
        run_random(40);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/tea_pkg.sv
design/tea_in_if.sv
design/tea_out_if.sv
design/tea_cell.sv
design/tea_seq.sv
design/tea_block_cipher.sv
tb/tea_block_cipher_tb.sv
